// ===== design/cps_pkg.sv =====
// Package: shared types, constants and codes for the process scheduler.
`default_nettype none
package cps_pkg;
  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_READY = 2'd1,
    ST_WAIT  = 2'd2,
    ST_RUN   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ARRIVE = 2'd1,
    ACT_IODONE = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_DONE    = 3'd2,
    EV_TO_IO   = 3'd3,
    EV_PREEMPT = 3'd4,
    EV_QUANTUM = 3'd5,
    EV_IDLE    = 3'd6
  } event_t;

  localparam logic [2:0] MODE_FCFS   = 3'd0;
  localparam logic [2:0] MODE_SJF_NP = 3'd1;
  localparam logic [2:0] MODE_SJF_P  = 3'd2;
  localparam logic [2:0] MODE_PRI_NP = 3'd3;
  localparam logic [2:0] MODE_PRI_P  = 3'd4;
  localparam logic [2:0] MODE_RR     = 3'd5;

  localparam logic [0:0] REG_MODE    = 1'd0;
  localparam logic [0:0] REG_QUANTUM = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_DECIDE,
    S_SCAN2,
    S_FINISH,
    S_OUT
  } state_t;

  // Scan request and result between sequencer and scan unit
  typedef struct packed {
    logic             start;
    logic             use_skip;
    logic [IDX_W-1:0] skip_idx;
  } scan_req_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] idx;
  } scan_rsp_t;
endpackage
`default_nettype wire

// ===== design/cps_scan.sv =====
// Scan unit: walks the table one entry a cycle and keeps the best ready entry.
`default_nettype none
module cps_scan
  import cps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire scan_req_t               req,
  input  wire logic [2:0]              mode,
  input  wire logic [15:0]             order_count,
  input  wire status_t                 status [TABLE_ENTRIES],
  input  wire logic [7:0]              prio   [TABLE_ENTRIES],
  input  wire logic [9:0]              left   [TABLE_ENTRIES],
  input  wire logic [15:0]             order  [TABLE_ENTRIES],
  output scan_rsp_t                    rsp
);
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [9:0]       bleft_r, bleft_nxt;
  logic [7:0]       bprio_r, bprio_nxt;
  logic [15:0]      bage_r, bage_nxt;
  logic             done_r, done_nxt;
  logic [IDX_W-1:0] cur;
  logic [15:0]      cage;
  logic             cand, better;

  assign cur  = ptr_r[IDX_W-1:0];
  assign cage = order_count - order[cur];
  assign cand = busy_r && status[cur] == ST_READY;

  // Compare the current entry against the best so far
  always_comb begin
    better = cage > bage_r;
    if (mode == MODE_SJF_NP || mode == MODE_SJF_P) begin
      if (left[cur] != bleft_r) better = left[cur] < bleft_r;
    end else if (mode == MODE_PRI_NP || mode == MODE_PRI_P) begin
      if (prio[cur] != bprio_r) better = prio[cur] > bprio_r;
    end
  end

  // Advance the scan pointer and update the running best
  always_comb begin
    busy_nxt  = busy_r;
    ptr_nxt   = ptr_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    bleft_nxt = bleft_r;
    bprio_nxt = bprio_r;
    bage_nxt  = bage_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      busy_nxt  = 1'b1;
      ptr_nxt   = '0;
      found_nxt = 1'b0;
    end else if (busy_r) begin
      if (cand && !(req.use_skip && cur == req.skip_idx) && (!found_r || better)) begin
        found_nxt = 1'b1;
        best_nxt  = cur;
        bleft_nxt = left[cur];
        bprio_nxt = prio[cur];
        bage_nxt  = cage;
      end
      if (ptr_r == CNT_W'(TABLE_ENTRIES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
    end
    ptr_r   <= ptr_nxt;
    best_r  <= best_nxt;
    bleft_r <= bleft_nxt;
    bprio_r <= bprio_nxt;
    bage_r  <= bage_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.found = found_r;
  assign rsp.idx   = best_r;
endmodule
`default_nettype wire

// ===== design/cpu_process_scheduler.sv =====
// Top level: process table, tick sequencer, configuration port and result register.
// Arrival, I/O-done and no-op items pass through the finish state before their result shows.
// Every tick makes one walk of the shared scan unit, one entry a cycle; the walk
// finds the best ready peer and the successor whether or not the runner leaves.
// One item is in work at a time; in_stall is high until the result is transferred.
// Reset frees all entries, clears counters and run state, sets mode 0 and quantum 2.
`default_nettype none
module cpu_process_scheduler
  import cps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_pid,
  input  wire logic [7:0]  in_prio,
  input  wire logic [9:0]  in_burst,
  input  wire logic        in_io_request,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_code,
  output logic [7:0]       out_old_pid,
  output logic [15:0]      out_turnaround,
  output logic             out_run_valid,
  output logic [7:0]       out_run_pid,
  output logic             out_started,
  output logic             out_table_full,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  // Configuration
  logic [2:0] mode_r;
  logic [7:0] qlen_r;
  logic [7:0] reload;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign reload = (qlen_r == 8'd0) ? 8'd1 : qlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FCFS;
      qlen_r <= 8'd2;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
      if (cfg_paddr[2] == REG_MODE) mode_r <= cfg_pwdata[2:0];
      else                          qlen_r <= cfg_pwdata[7:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_MODE) cfg_prdata = {29'd0, mode_r};
    else                          cfg_prdata = {24'd0, qlen_r};
  end

  // Process table
  status_t     status_r [TABLE_ENTRIES];
  logic [7:0]  pid_r    [TABLE_ENTRIES];
  logic [7:0]  prio_r   [TABLE_ENTRIES];
  logic [9:0]  left_r   [TABLE_ENTRIES];
  logic [15:0] arr_r    [TABLE_ENTRIES];
  logic [15:0] order_r  [TABLE_ENTRIES];

  logic             run_act_r;
  logic [IDX_W-1:0] run_slot_r;
  logic [7:0]       qleft_r;
  logic [15:0]      tick_r, ocnt_r;

  // Latched item
  logic [1:0]  act_r;
  logic [7:0]  ipid_r, iprio_r;
  logic [9:0]  iburst_r;
  logic        iio_r;
  logic [9:0]  rleft_r;

  // Result fields
  logic [2:0]  ev_r;
  logic [7:0]  old_r;
  logic [15:0] ta_r;
  logic        started_r, full_r, ovalid_r;

  state_t      st_r, st_nxt;
  scan_req_t   sreq;
  scan_rsp_t   srsp;

  cps_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (sreq),
    .mode        (mode_r),
    .order_count (ocnt_r),
    .status      (status_r),
    .prio        (prio_r),
    .left        (left_r),
    .order       (order_r),
    .rsp         (srsp)
  );

  // First free entry and first waiting entry with matching pid
  logic             free_found, wait_found;
  logic [IDX_W-1:0] free_idx, wait_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    wait_found = 1'b0;
    wait_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (status_r[i] == ST_FREE) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (status_r[i] == ST_WAIT && pid_r[i] == ipid_r) begin
        wait_found = 1'b1;
        wait_idx   = IDX_W'(i);
      end
    end
  end

  // Decide step values for a running process
  logic [9:0] dec_left;
  logic [7:0] qdec;
  logic       preempt, q_exp;
  assign dec_left = (left_r[run_slot_r] > 10'd0) ? left_r[run_slot_r] - 10'd1 : 10'd0;
  assign qdec     = (qleft_r > 8'd0) ? qleft_r - 8'd1 : 8'd0;
  always_comb begin
    preempt = 1'b0;
    if (mode_r == MODE_SJF_P)
      preempt = srsp.found && rleft_r > left_r[srsp.idx];
    else if (mode_r == MODE_PRI_P)
      preempt = srsp.found && prio_r[run_slot_r] < prio_r[srsp.idx];
  end
  assign q_exp = !preempt && mode_r == MODE_RR && qdec == 8'd0;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = ovalid_r && !out_stall;
  assign in_stall = st_r != S_IDLE;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:   if (in_acc) st_nxt = (in_action == ACT_TICK) ?
                                     (run_act_r ? S_DECIDE : S_SCAN2) : S_FINISH;
      S_DECIDE: st_nxt = S_SCAN1;
      S_SCAN1:  if (srsp.done) st_nxt = S_FINISH;
      S_SCAN2:  if (srsp.done) st_nxt = S_FINISH;
      S_FINISH: st_nxt = S_OUT;
      S_OUT:    if (out_acc) st_nxt = S_IDLE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  // Scan requests: a tick that runs a process first walks for the best peer
  always_comb begin
    sreq.start    = 1'b0;
    sreq.use_skip = 1'b0;
    sreq.skip_idx = run_slot_r;
    unique case (st_r)
      S_IDLE:   sreq.start = in_acc && in_action == ACT_TICK;
      default:  sreq.start = 1'b0;
    endcase
  end

  // Phase flag: set when the runner leaves in the decide step, so the scan result picks a successor
  logic pick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      run_act_r <= 1'b0;
      run_slot_r <= '0;
      qleft_r   <= 8'd2;
      tick_r    <= '0;
      ocnt_r    <= '0;
      ovalid_r  <= 1'b0;
      pick_r    <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) status_r[i] <= ST_FREE;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: if (in_acc) begin
          act_r    <= in_action;
          ipid_r   <= in_pid;
          iprio_r  <= in_prio;
          iburst_r <= in_burst;
          iio_r    <= in_io_request;
          ev_r     <= EV_NONE;
          old_r    <= '0;
          ta_r     <= '0;
          started_r <= 1'b0;
          full_r   <= 1'b0;
          pick_r   <= 1'b0;
        end
        S_DECIDE: begin
          // Charge one unit to the running process
          left_r[run_slot_r] <= dec_left;
          rleft_r <= dec_left;
          if (iio_r) begin
            ev_r  <= EV_TO_IO;
            old_r <= pid_r[run_slot_r];
            status_r[run_slot_r] <= ST_WAIT;
            run_act_r <= 1'b0;
            pick_r <= 1'b1;
          end else if (dec_left == 10'd0) begin
            ev_r  <= EV_DONE;
            old_r <= pid_r[run_slot_r];
            ta_r  <= tick_r - arr_r[run_slot_r];
            status_r[run_slot_r] <= ST_FREE;
            run_act_r <= 1'b0;
            pick_r <= 1'b1;
          end
        end
        S_SCAN1: if (srsp.done) begin
          if (!pick_r) begin
            // Still running: preemption or quantum check against the best peer
            if (preempt || (q_exp && srsp.found)) begin
              ev_r  <= preempt ? EV_PREEMPT : EV_QUANTUM;
              old_r <= pid_r[run_slot_r];
              status_r[run_slot_r] <= ST_READY;
              order_r[run_slot_r]  <= ocnt_r;
              ocnt_r <= ocnt_r + 16'd1;
              status_r[srsp.idx] <= ST_RUN;
              run_slot_r <= srsp.idx;
              run_act_r  <= 1'b1;
              qleft_r    <= reload;
              started_r  <= 1'b1;
            end else if (mode_r == MODE_RR) begin
              qleft_r <= (qdec == 8'd0) ? reload : qdec;
            end
          end else if (srsp.found) begin
            status_r[srsp.idx] <= ST_RUN;
            run_slot_r <= srsp.idx;
            run_act_r  <= 1'b1;
            qleft_r    <= reload;
            started_r  <= 1'b1;
          end
        end
        S_SCAN2: if (srsp.done) begin
          if (srsp.found) begin
            status_r[srsp.idx] <= ST_RUN;
            run_slot_r <= srsp.idx;
            run_act_r  <= 1'b1;
            qleft_r    <= reload;
            started_r  <= 1'b1;
            ev_r <= EV_START;
          end else begin
            ev_r <= EV_IDLE;
          end
        end
        S_FINISH: begin
          ovalid_r <= 1'b1;
          if (act_r == ACT_TICK) begin
            if (tick_r != 16'hFFFF) tick_r <= tick_r + 16'd1;
          end else if (act_r == ACT_ARRIVE) begin
            if (free_found) begin
              status_r[free_idx] <= ST_READY;
              pid_r[free_idx]    <= ipid_r;
              prio_r[free_idx]   <= iprio_r;
              left_r[free_idx]   <= iburst_r;
              arr_r[free_idx]    <= tick_r;
              order_r[free_idx]  <= ocnt_r;
              ocnt_r <= ocnt_r + 16'd1;
            end else begin
              full_r <= 1'b1;
            end
          end else if (act_r == ACT_IODONE) begin
            if (wait_found) begin
              status_r[wait_idx] <= ST_READY;
              order_r[wait_idx]  <= ocnt_r;
              ocnt_r <= ocnt_r + 16'd1;
            end
          end
        end
        S_OUT: if (out_acc) ovalid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // Result ports
  assign out_valid      = ovalid_r;
  assign out_event_code = ev_r;
  assign out_old_pid    = old_r;
  assign out_turnaround = ta_r;
  assign out_run_valid  = run_act_r;
  assign out_run_pid    = run_act_r ? pid_r[run_slot_r] : 8'd0;
  assign out_started    = started_r;
  assign out_table_full = full_r;

  // Checks
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> in_stall) else $error("input open while result pending");
  a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && run_act_r) |-> status_r[run_slot_r] == ST_RUN)
    else $error("running slot not marked running");
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && started_r) |-> run_act_r) else $error("started without a runner");
endmodule
`default_nettype wire
